FILE: hw/rtl/ipv4rhc_pkg.sv
package ipv4rhc_pkg;

   // Verdict codes carried in the result word.
   typedef logic [2:0] verdict_type;
   localparam verdict_type VERDICT_LOCAL       = 3'd0;
   localparam verdict_type VERDICT_FRAGMENT    = 3'd1;
   localparam verdict_type VERDICT_FORWARD     = 3'd2;
   localparam verdict_type VERDICT_BAD_VERSION = 3'd3;
   localparam verdict_type VERDICT_BAD_LENGTH  = 3'd4;
   localparam verdict_type VERDICT_NOT_MINE    = 3'd5;
   localparam verdict_type VERDICT_BAD_SUM     = 3'd6;

   // Control register indexes.
   typedef logic [1:0] csr_index_type;
   localparam csr_index_type CSR_LOCAL_ADDRESS  = 2'd0;
   localparam csr_index_type CSR_SUBNET_MASK    = 2'd1;
   localparam csr_index_type CSR_FORWARD_ENABLE = 2'd2;

   // Header constants.
   localparam logic [3:0]  VERSION_FOUR = 4'd4;
   localparam logic [3:0]  MIN_IHL      = 4'd5;
   localparam logic [15:0] SUM_GOOD     = 16'hffff;
   localparam logic [31:0] ALL_ONES     = 32'hffff_ffff;

   // Position of each captured field within the header, in 16-bit words.
   localparam logic [4:0] WORD_LENGTH      = 5'd1;
   localparam logic [4:0] WORD_FRAGMENT    = 5'd3;
   localparam logic [4:0] WORD_PROTOCOL    = 5'd4;
   localparam logic [4:0] WORD_SOURCE_HIGH = 5'd6;
   localparam logic [4:0] WORD_SOURCE_LOW  = 5'd7;
   localparam logic [4:0] WORD_DEST_HIGH   = 5'd8;
   localparam logic [4:0] WORD_DEST_LOW    = 5'd9;

   typedef struct packed {
      logic        first_word;
      logic [15:0] header_word;
   } req_payload_type;

   typedef struct packed {
      verdict_type verdict;
      logic [7:0]  upper_protocol;
      logic [15:0] total_length;
      logic [5:0]  header_bytes;
      logic [15:0] fragment_offset;
      logic        more_fragments;
      logic [31:0] source_address;
      logic [31:0] dest_address;
   } rsp_payload_type;

endpackage

FILE: hw/rtl/ipv4_receive_header_check.sv
// IPv4 receive header checker. Header words enter on the req_ channel as 16-bit words in
// network byte order, one word per handshake, with first_word set on the first word of
// each header. The block keeps a running ones'-complement sum and captures the total
// length, fragment word, protocol, source and destination as they pass, and gives one
// verdict word on the rsp_ channel per header: on the first word if the version is not
// four or the header length is below five 32-bit words, otherwise on the last header word
// (IHL times two). The destination is tested first (own address, subnet broadcast or
// all-ones, forwarding when enabled, else not mine), then the checksum, then whether the
// packet is a fragment. Words after an error or after a verdict are ignored until the
// next first word, and a first word in the middle of a header abandons that header
// silently. The block sustains one word per clock; a verdict appears in the result register on
// the cycle after its word is accepted, and the input stalls only while that register holds a
// word that rsp_ready has not yet taken. The csr_ port is always ready; write it only while the
// block is idle.
module ipv4_receive_header_check (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  ipv4rhc_pkg::req_payload_type  req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output ipv4rhc_pkg::rsp_payload_type  rsp_payload,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  ipv4rhc_pkg::csr_index_type    csr_index,
   input  logic [31:0]                   csr_data
);
   import ipv4rhc_pkg::*;

   // Control registers.
   logic [31:0] local_address_ff;
   logic [31:0] subnet_mask_ff;
   logic        forward_enable_ff;

   // Per-header state.
   logic [4:0]  word_count_ff, word_count_in;
   logic [15:0] sum_ff, sum_in;
   logic [3:0]  header_words_ff, header_words_in;
   logic        skipping_ff, skipping_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] fragment_ff, fragment_in;
   logic [7:0]  protocol_ff, protocol_in;
   logic [31:0] source_ff, source_in;
   logic [31:0] dest_ff, dest_in;

   // Result register.
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic        req_fire;
   logic        is_first;
   logic [15:0] word;
   logic [3:0]  version;
   logic [3:0]  ihl;
   logic        bad_version;
   logic        bad_length;
   logic        active;
   logic        last_word;
   logic        produce;
   logic [4:0]  base_count;
   logic [15:0] base_sum;
   logic [16:0] sum_wide;
   logic [15:0] sum_new;
   logic [31:0] host_mask;
   logic        same_network;
   logic        is_bcast;
   verdict_type verdict;

   // The output register parts the two sides: a new word is taken whenever the
   // register is empty or its word is being taken in the same cycle.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign is_first = req_payload.first_word;
   assign word     = req_payload.header_word;
   assign version  = word[15:12];
   assign ihl      = word[11:8];

   assign bad_version = is_first && (version != VERSION_FOUR);
   assign bad_length  = is_first && (version == VERSION_FOUR) && (ihl < MIN_IHL);
   assign active      = is_first || !skipping_ff;

   // A first word restarts the header: counters, sum and captures start from zero.
   assign base_count      = is_first ? 5'd0 : word_count_ff;
   assign base_sum        = is_first ? 16'd0 : sum_ff;
   assign header_words_in = is_first ? ihl : header_words_ff;

   // Ones'-complement add with end-around carry.
   assign sum_wide = {1'b0, base_sum} + {1'b0, word};
   assign sum_new  = sum_wide[15:0] + {15'd0, sum_wide[16]};

   assign last_word = ({1'b0, base_count} + 6'd1) == {1'b0, header_words_in, 1'b0};

   // Field captures, taken from the word at its fixed position in the header.
   always_comb begin
      length_in   = is_first ? 16'd0 : length_ff;
      fragment_in = is_first ? 16'd0 : fragment_ff;
      protocol_in = is_first ? 8'd0  : protocol_ff;
      source_in   = is_first ? 32'd0 : source_ff;
      dest_in     = is_first ? 32'd0 : dest_ff;
      if (!bad_version && !bad_length) begin
         unique case (base_count)
            WORD_LENGTH:      length_in   = word;
            WORD_FRAGMENT:    fragment_in = word;
            WORD_PROTOCOL:    protocol_in = word[7:0];
            WORD_SOURCE_HIGH: source_in   = {word, source_in[15:0]};
            WORD_SOURCE_LOW:  source_in   = {source_in[31:16], word};
            WORD_DEST_HIGH:   dest_in     = {word, dest_in[15:0]};
            WORD_DEST_LOW:    dest_in     = {dest_in[31:16], word};
            default: begin
            end
         endcase
      end
   end

   // Destination, checksum and fragment tests, in that order of precedence.
   assign host_mask    = ~subnet_mask_ff;
   assign same_network = (dest_in & subnet_mask_ff) == (local_address_ff & subnet_mask_ff);
   assign is_bcast     = (dest_in & host_mask) == host_mask;

   always_comb begin
      priority if (dest_in != local_address_ff && forward_enable_ff && !same_network
                   && dest_in != ALL_ONES) begin
         verdict = is_bcast ? VERDICT_NOT_MINE : VERDICT_FORWARD;
      end else if (dest_in != local_address_ff && !is_bcast) begin
         verdict = VERDICT_NOT_MINE;
      end else if (sum_new != SUM_GOOD) begin
         verdict = VERDICT_BAD_SUM;
      end else if (fragment_in[13] || (fragment_in[12:0] != 13'd0)) begin
         verdict = VERDICT_FRAGMENT;
      end else begin
         verdict = VERDICT_LOCAL;
      end
   end

   // Next state of the header tracking and the result word.
   always_comb begin
      word_count_in  = word_count_ff;
      sum_in         = sum_ff;
      skipping_in    = skipping_ff;
      produce        = 1'b0;
      rsp_payload_in = rsp_payload_ff;
      if (bad_version || bad_length) begin
         word_count_in                 = 5'd0;
         sum_in                        = 16'd0;
         skipping_in                   = 1'b1;
         produce                       = 1'b1;
         rsp_payload_in                = '0;
         rsp_payload_in.verdict        = bad_version ? VERDICT_BAD_VERSION : VERDICT_BAD_LENGTH;
         rsp_payload_in.header_bytes   = {ihl, 2'b00};
      end else if (active) begin
         word_count_in = base_count + 5'd1;
         sum_in        = sum_new;
         skipping_in   = last_word;
         produce       = last_word;
         rsp_payload_in.verdict         = verdict;
         rsp_payload_in.upper_protocol  = protocol_in;
         rsp_payload_in.total_length    = length_in;
         rsp_payload_in.header_bytes    = {header_words_in, 2'b00};
         rsp_payload_in.fragment_offset = {fragment_in[12:0], 3'b000};
         rsp_payload_in.more_fragments  = fragment_in[13];
         rsp_payload_in.source_address  = source_in;
         rsp_payload_in.dest_address    = dest_in;
      end
   end

   always_comb begin
      if (req_fire && produce) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_count_ff   <= '0;
         sum_ff          <= '0;
         header_words_ff <= '0;
         skipping_ff     <= 1'b1;
         length_ff       <= '0;
         fragment_ff     <= '0;
         protocol_ff     <= '0;
         source_ff       <= '0;
         dest_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            word_count_ff   <= word_count_in;
            sum_ff          <= sum_in;
            header_words_ff <= header_words_in;
            skipping_ff     <= skipping_in;
            length_ff       <= length_in;
            fragment_ff     <= fragment_in;
            protocol_ff     <= protocol_in;
            source_ff       <= source_in;
            dest_ff         <= dest_in;
         end
      end
   end

   // The result payload needs no reset: it is only looked at while rsp_valid is high.
   always_ff @(posedge clock) begin
      if (req_fire && produce) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   // Control register writes; an index beyond the list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         local_address_ff  <= '0;
         subnet_mask_ff    <= '0;
         forward_enable_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_LOCAL_ADDRESS:  local_address_ff  <= csr_data;
            CSR_SUBNET_MASK:    subnet_mask_ff    <= csr_data;
            CSR_FORWARD_ENABLE: forward_enable_ff <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

FILE: hw/rtl/ipv4rhc_checker.sv
module ipv4rhc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input ipv4rhc_pkg::req_payload_type  req_payload,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input ipv4rhc_pkg::rsp_payload_type  rsp_payload,
   input logic                          csr_valid,
   input logic                          csr_ready,
   input ipv4rhc_pkg::csr_index_type    csr_index,
   input logic [31:0]                   csr_data
);
   import ipv4rhc_pkg::*;

   // A result word that is not taken stays, unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result word changed or dropped while stalled");

   // The input is never stalled while the result register is free.
   a_req_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with an empty result register");

   // A first word of the wrong version is answered on the next cycle.
   a_bad_version: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_payload.first_word
         && req_payload.header_word[15:12] != VERSION_FOUR
      |=> rsp_valid && rsp_payload.verdict == VERDICT_BAD_VERSION)
      else $error("bad version not reported");

   // Header length is always a whole number of 32-bit words and verdicts are defined codes.
   a_rsp_sane: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.header_bytes[1:0] == 2'b00
                    && rsp_payload.verdict <= VERDICT_BAD_SUM)
      else $error("malformed result word");

   // The control port never pushes back.
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("control write stalled");

endmodule

bind ipv4_receive_header_check ipv4rhc_checker u_checker (.*);
